// ----- src/ecu_pkg.sv -----
// Shared types, constants and the quarter-wave sine table of the easing curve unit.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package ecu_pkg;

  // Fixed-point format: unsigned, FRAC_BITS fraction bits, ONE means 1.0.
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = FRAC_BITS + 1;
  localparam logic [VAL_W-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VAL_W-1:0] HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  // Sine table geometry.
  localparam int SINE_DEPTH = 256;
  localparam int TBL_IDX_W  = $clog2(SINE_DEPTH + 1);
  localparam int SEG_IDX_W  = $clog2(SINE_DEPTH);
  localparam int POS_W      = FRAC_BITS + TBL_IDX_W;

  // Bounce and multiplier widths: 22 * ONE stays below 32 * ONE.
  localparam int W_W    = FRAC_BITS + 5;
  localparam int PROD_W = 2 * W_W;
  localparam int NUM_W  = PROD_W + 1;

  // pi/2 in Q30.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Curve selector codes.
  localparam logic [2:0] MODE_LINEAR       = 3'd0;
  localparam logic [2:0] MODE_SINE_IN      = 3'd1;
  localparam logic [2:0] MODE_SINE_OUT     = 3'd2;
  localparam logic [2:0] MODE_SINE_INOUT   = 3'd3;
  localparam logic [2:0] MODE_BOUNCE_IN    = 3'd4;
  localparam logic [2:0] MODE_BOUNCE_OUT   = 3'd5;
  localparam logic [2:0] MODE_BOUNCE_INOUT = 3'd6;
  localparam logic [2:0] MODE_LINEAR_ALT   = 3'd7;

  typedef enum logic [1:0] {
    CURVE_LINEAR,
    CURVE_SINE,
    CURVE_BOUNCE
  } curve_t;

  // How the core curve value f is folded into the result.
  typedef enum logic [1:0] {
    SHAPE_OUT,       // f
    SHAPE_IN,        // ONE - f
    SHAPE_INOUT_LO,  // (ONE - f + 1) / 2
    SHAPE_INOUT_HI   // (ONE + f + 1) / 2
  } shape_t;

  // Stage 1 result: decoded curve and folded argument.
  typedef struct packed {
    curve_t           curve;
    shape_t           shape;
    logic [VAL_W-1:0] prog;
    logic [VAL_W-1:0] arg;
  } front_t;

  // Stage 2 result: table base, bounce offset and multiplier operands.
  typedef struct packed {
    curve_t           curve;
    shape_t           shape;
    logic [VAL_W-1:0] prog;
    logic [VAL_W-1:0] base;
    logic [5:0]       kcoef;
    logic [W_W-1:0]   mul_a;
    logic [W_W-1:0]   mul_b;
  } mid_t;

  // Stage 3 result: the product and what the final stage still needs.
  typedef struct packed {
    curve_t            curve;
    shape_t            shape;
    logic [VAL_W-1:0]  prog;
    logic [VAL_W-1:0]  base;
    logic [5:0]        kcoef;
    logic [PROD_W-1:0] prod;
  } prod_t;

  typedef logic [VAL_W-1:0] sine_tbl_t [0:SINE_DEPTH];

  // Sine of x (Q30 radians) by a Taylor series in integer arithmetic.
  function automatic logic [63:0] sine_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    int                 k;
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    k    = 1;
    while (k < 16 && term != 64'd0) begin
      term = ((term * x2) >> 30) / 64'(2 * k * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = acc - $signed(term);
      end else begin
        acc = acc + $signed(term);
      end
      k = k + 1;
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (64'sd1 <<< 30)) begin
      acc = 64'sd1 <<< 30;
    end
    return acc;
  endfunction

  // Table points round(sin(pi/2 * i / SINE_DEPTH) * ONE), worked out at elaboration.
  function automatic sine_tbl_t build_sine_tbl();
    sine_tbl_t   tbl;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x = (64'(i) * HALF_PI_Q30) / 64'(SINE_DEPTH);
      s = sine_q30(x);
      v = (s + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      if (v > 64'(ONE)) begin
        v = 64'(ONE);
      end
      tbl[i] = v[VAL_W-1:0];
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage

// ----- src/easing_curve_unit.sv -----
// Top level of the easing curve unit: pipeline control and the stage modules.
// Depends on ecu_pkg, ecu_front, ecu_curve and ecu_back.
//
// Usage:
//   The input channel carries a curve selector (in_mode) and a progress value
//   (in_progress, 16 fraction bits, 65536 is 1.0). One transaction moves when
//   in_valid is high and in_stall is low. The result channel returns the eased
//   progress on out_eased under out_valid / out_stall, one result per input,
//   in input order, saturated to 0..1.0.
//   The result is registered through four register stages (decode, table lookup,
//   shared multiplier, rounding and folding), each holding one item. Throughput
//   is one transaction per cycle while the receiver does not stall, so a new item
//   enters every cycle unless the output is stalled.
//   When the receiver stalls, each stage holds its item and fills the empty
//   stages behind it; in_stall rises only once all four stages are occupied.
//   Synchronous reset empties the pipeline; no transaction is pending after it.
//   The sine table is a constant and needs no initialization.
`timescale 1ns / 1ps

module easing_curve_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_mode,
  input  logic [ecu_pkg::VAL_W-1:0] in_progress,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [ecu_pkg::VAL_W-1:0] out_eased
);

  logic v1_r, v2_r, v3_r, out_valid_r;
  logic v1_nxt, v2_nxt, v3_nxt, out_valid_nxt;
  logic rdy1, rdy2, rdy3, rdy_out;

  ecu_pkg::front_t front_q;
  ecu_pkg::prod_t  prod_q;

  // Each stage can take a transaction when it is empty or passes its item on.
  always_comb begin
    rdy_out = !out_valid_r || !out_stall;
    rdy3    = !v3_r || rdy_out;
    rdy2    = !v2_r || rdy3;
    rdy1    = !v1_r || rdy2;

    v1_nxt        = rdy1 ? in_valid : v1_r;
    v2_nxt        = rdy2 ? v1_r : v2_r;
    v3_nxt        = rdy3 ? v2_r : v3_r;
    out_valid_nxt = rdy_out ? v3_r : out_valid_r;
  end

  // Valid bits travel alongside the payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      v3_r        <= v3_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  ecu_front u_front (
    .clk      (clk),
    .en       (rdy1 && in_valid),
    .mode     (in_mode),
    .progress (in_progress),
    .q        (front_q)
  );

  ecu_curve u_curve (
    .clk     (clk),
    .en_mid  (rdy2 && v1_r),
    .en_prod (rdy3 && v2_r),
    .d       (front_q),
    .q       (prod_q)
  );

  ecu_back u_back (
    .clk   (clk),
    .en    (rdy_out && v3_r),
    .d     (prod_q),
    .eased (out_eased)
  );

  assign in_stall  = !rdy1;
  assign out_valid = out_valid_r;

endmodule

// ----- src/ecu_front.sv -----
// First pipeline stage: saturates progress, decodes the selector and folds the argument.
// Depends on ecu_pkg.
`timescale 1ns / 1ps

module ecu_front (
  input  logic                    clk,
  input  logic                    en,
  input  logic [2:0]              mode,
  input  logic [ecu_pkg::VAL_W-1:0] progress,
  output ecu_pkg::front_t         q
);

  ecu_pkg::front_t          front_r;
  ecu_pkg::front_t          front_nxt;
  logic [ecu_pkg::VAL_W-1:0] p_sat;
  logic [ecu_pkg::VAL_W:0]   p_dbl;
  logic                     lower_half;

  // Decode the curve and pick the argument of the core curve.
  always_comb begin
    p_sat      = (progress > ecu_pkg::ONE) ? ecu_pkg::ONE : progress;
    p_dbl      = {p_sat, 1'b0};
    lower_half = (p_sat < ecu_pkg::HALF);

    front_nxt.curve = ecu_pkg::CURVE_LINEAR;
    front_nxt.shape = ecu_pkg::SHAPE_OUT;
    front_nxt.prog  = p_sat;
    front_nxt.arg   = p_sat;

    case (mode)
      ecu_pkg::MODE_SINE_IN, ecu_pkg::MODE_BOUNCE_IN: begin
        front_nxt.shape = ecu_pkg::SHAPE_IN;
        front_nxt.arg   = ecu_pkg::ONE - p_sat;
      end
      ecu_pkg::MODE_SINE_OUT, ecu_pkg::MODE_BOUNCE_OUT: begin
        front_nxt.shape = ecu_pkg::SHAPE_OUT;
        front_nxt.arg   = p_sat;
      end
      ecu_pkg::MODE_SINE_INOUT, ecu_pkg::MODE_BOUNCE_INOUT: begin
        if (lower_half) begin
          front_nxt.shape = ecu_pkg::SHAPE_INOUT_LO;
          front_nxt.arg   = ecu_pkg::VAL_W'({1'b0, ecu_pkg::ONE} - p_dbl);
        end else begin
          front_nxt.shape = ecu_pkg::SHAPE_INOUT_HI;
          front_nxt.arg   = ecu_pkg::VAL_W'(p_dbl - {1'b0, ecu_pkg::ONE});
        end
      end
      default: begin
        front_nxt.shape = ecu_pkg::SHAPE_OUT;
      end
    endcase

    case (mode)
      ecu_pkg::MODE_SINE_IN, ecu_pkg::MODE_SINE_OUT, ecu_pkg::MODE_SINE_INOUT: begin
        front_nxt.curve = ecu_pkg::CURVE_SINE;
      end
      ecu_pkg::MODE_BOUNCE_IN, ecu_pkg::MODE_BOUNCE_OUT, ecu_pkg::MODE_BOUNCE_INOUT: begin
        front_nxt.curve = ecu_pkg::CURVE_BOUNCE;
      end
      ecu_pkg::MODE_LINEAR, ecu_pkg::MODE_LINEAR_ALT: begin
        front_nxt.curve = ecu_pkg::CURVE_LINEAR;
      end
      default: begin
        front_nxt.curve = ecu_pkg::CURVE_LINEAR;
      end
    endcase
  end

  // Payload register, loaded when the stage takes a transaction.
  always_ff @(posedge clk) begin
    if (en) begin
      front_r <= front_nxt;
    end
  end

  assign q = front_r;

endmodule

// ----- src/ecu_curve.sv -----
// Second and third pipeline stages: sine table lookup or bounce segment selection,
// then one shared multiplier for the interpolation or the quadratic. Depends on ecu_pkg.
`timescale 1ns / 1ps

module ecu_curve (
  input  logic            clk,
  input  logic            en_mid,
  input  logic            en_prod,
  input  ecu_pkg::front_t d,
  output ecu_pkg::prod_t  q
);

  localparam int W_W = ecu_pkg::W_W;
  localparam int F   = ecu_pkg::FRAC_BITS;

  localparam logic [W_W-1:0] SEG1_LIM = W_W'(4) << F;
  localparam logic [W_W-1:0] SEG2_LIM = W_W'(8) << F;
  localparam logic [W_W-1:0] SEG3_LIM = W_W'(10) << F;

  ecu_pkg::mid_t  mid_r;
  ecu_pkg::mid_t  mid_nxt;
  ecu_pkg::prod_t prod_r;
  ecu_pkg::prod_t prod_nxt;

  logic [ecu_pkg::POS_W-1:0]     pos;
  logic [ecu_pkg::SEG_IDX_W-1:0] seg_idx;
  logic [F-1:0]                  frac;
  logic [ecu_pkg::VAL_W-1:0]     t0;
  logic [ecu_pkg::VAL_W-1:0]     t1;
  logic [ecu_pkg::VAL_W-1:0]     delta;
  logic [W_W-1:0]                x11;
  logic [W_W-1:0]                x22;
  logic [W_W-1:0]                c_one;
  logic [5:0]                    kcoef;
  logic [W_W-1:0]                w;

  // Sine lookup: two neighboring table points and the interpolation fraction.
  always_comb begin
    pos     = ecu_pkg::POS_W'(d.arg[F-1:0]) * ecu_pkg::POS_W'(ecu_pkg::SINE_DEPTH);
    seg_idx = pos[F +: ecu_pkg::SEG_IDX_W];
    if (d.arg[F]) begin
      // Argument at one: the last table point, no interpolation.
      frac = '0;
      t0   = ecu_pkg::SINE_TBL[ecu_pkg::SINE_DEPTH];
      t1   = t0;
    end else begin
      frac = pos[F-1:0];
      t0   = ecu_pkg::SINE_TBL[ecu_pkg::TBL_IDX_W'(seg_idx)];
      t1   = ecu_pkg::SINE_TBL[ecu_pkg::TBL_IDX_W'(seg_idx) + 1'b1];
      if (t1 < t0) begin
        t1 = t0;
      end
    end
    delta = t1 - t0;
  end

  // Bounce: pick the segment and the distance from its vertex.
  always_comb begin
    x11 = W_W'(d.arg) * W_W'(11);
    x22 = {x11[W_W-2:0], 1'b0};
    if (x11 < SEG1_LIM) begin
      c_one = '0;
      kcoef = 6'd0;
    end else if (x11 < SEG2_LIM) begin
      c_one = W_W'(12) << F;
      kcoef = 6'd48;
    end else if (x11 < SEG3_LIM) begin
      c_one = W_W'(18) << F;
      kcoef = 6'd60;
    end else begin
      c_one = W_W'(21) << F;
      kcoef = 6'd63;
    end
    w = (x22 >= c_one) ? (x22 - c_one) : (c_one - x22);
  end

  // Route the curve's operands to the shared multiplier.
  always_comb begin
    mid_nxt.curve = d.curve;
    mid_nxt.shape = d.shape;
    mid_nxt.prog  = d.prog;
    mid_nxt.base  = t0;
    mid_nxt.kcoef = kcoef;
    case (d.curve)
      ecu_pkg::CURVE_SINE: begin
        mid_nxt.mul_a = W_W'(delta);
        mid_nxt.mul_b = W_W'(frac);
      end
      ecu_pkg::CURVE_BOUNCE: begin
        mid_nxt.mul_a = w;
        mid_nxt.mul_b = w;
      end
      default: begin
        mid_nxt.mul_a = '0;
        mid_nxt.mul_b = '0;
      end
    endcase
  end

  // Multiply stage.
  always_comb begin
    prod_nxt.curve = mid_r.curve;
    prod_nxt.shape = mid_r.shape;
    prod_nxt.prog  = mid_r.prog;
    prod_nxt.base  = mid_r.base;
    prod_nxt.kcoef = mid_r.kcoef;
    prod_nxt.prod  = ecu_pkg::PROD_W'(mid_r.mul_a) * ecu_pkg::PROD_W'(mid_r.mul_b);
  end

  always_ff @(posedge clk) begin
    if (en_mid) begin
      mid_r <= mid_nxt;
    end
    if (en_prod) begin
      prod_r <= prod_nxt;
    end
  end

  assign q = prod_r;

endmodule

// ----- src/ecu_back.sv -----
// Final pipeline stage: rounds the curve value, folds it into the result and saturates.
// Depends on ecu_pkg.
`timescale 1ns / 1ps

module ecu_back (
  input  logic                      clk,
  input  logic                      en,
  input  ecu_pkg::prod_t            d,
  output logic [ecu_pkg::VAL_W-1:0] eased
);

  localparam int F     = ecu_pkg::FRAC_BITS;
  localparam int VAL_W = ecu_pkg::VAL_W;
  localparam int NUM_W = ecu_pkg::NUM_W;

  logic [VAL_W-1:0]          eased_r;
  logic [VAL_W-1:0]          eased_nxt;
  logic [ecu_pkg::PROD_W:0]  sine_rnd;
  logic [VAL_W:0]            sine_f;
  logic [NUM_W-1:0]          num;
  logic [NUM_W-1:0]          bounce_q;
  logic [VAL_W-1:0]          f;
  logic [VAL_W:0]            folded;

  always_comb begin
    // Sine: base point plus the rounded interpolation step.
    sine_rnd = (ecu_pkg::PROD_W + 1)'(d.prod) + ((ecu_pkg::PROD_W + 1)'(1) << (F - 1));
    sine_f   = (VAL_W + 1)'(d.base) + (VAL_W + 1)'(sine_rnd >> F);

    // Bounce: (w*w + K*ONE*ONE + 32*ONE) / (64*ONE), rounded half up by the bias.
    num      = NUM_W'(d.prod) + (NUM_W'(d.kcoef) << (2 * F)) + (NUM_W'(32) << F);
    bounce_q = num >> (F + 6);

    case (d.curve)
      ecu_pkg::CURVE_SINE: begin
        f = (sine_f > (VAL_W + 1)'(ecu_pkg::ONE)) ? ecu_pkg::ONE : sine_f[VAL_W-1:0];
      end
      ecu_pkg::CURVE_BOUNCE: begin
        f = (bounce_q > NUM_W'(ecu_pkg::ONE)) ? ecu_pkg::ONE : bounce_q[VAL_W-1:0];
      end
      default: begin
        f = d.prog;
      end
    endcase

    // Fold the curve value according to the in, out or in-out shape.
    case (d.shape)
      ecu_pkg::SHAPE_IN: begin
        folded = {1'b0, ecu_pkg::ONE - f};
      end
      ecu_pkg::SHAPE_INOUT_LO: begin
        folded = ({1'b0, ecu_pkg::ONE} - {1'b0, f} + (VAL_W + 1)'(1)) >> 1;
      end
      ecu_pkg::SHAPE_INOUT_HI: begin
        folded = ({1'b0, ecu_pkg::ONE} + {1'b0, f} + (VAL_W + 1)'(1)) >> 1;
      end
      default: begin
        folded = {1'b0, f};
      end
    endcase

    eased_nxt = (folded > (VAL_W + 1)'(ecu_pkg::ONE)) ? ecu_pkg::ONE : folded[VAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eased_r <= eased_nxt;
    end
  end

  assign eased = eased_r;

endmodule

// ----- src/ecu_checker.sv -----
// Port-level checks of the easing curve unit and the bind that attaches them.
// Depends on ecu_pkg and easing_curve_unit.
`timescale 1ns / 1ps

module ecu_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [ecu_pkg::VAL_W-1:0] out_eased
);

  // A stalled result stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_eased))
    else $error("result changed while stalled");

  // Results never leave the range 0 to 1.0.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_eased <= ecu_pkg::ONE)
    else $error("result above one");

  // Input backpressure only comes from a full pipeline behind a stalled output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind easing_curve_unit ecu_checker u_ecu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_eased (out_eased)
);

// ----- bench/easing_curve_unit_test.sv -----
// Self-checking testbench of the easing curve unit: a directed table, then random transactions.
// Depends on ecu_pkg for port widths and curve codes and on easing_curve_unit as the device.
`timescale 1ns / 1ps

module easing_curve_unit_test;

  localparam int W = ecu_pkg::VAL_W;

  // Fixed-point format and sine table geometry of the predictor.
  localparam bit [63:0] UNIT             = 64'd65536;
  localparam bit [63:0] HALF_UNIT        = 64'd32768;
  localparam int        SINE_PTS         = 256;
  localparam bit [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

  localparam int RANDOM_ITEMS = 1700;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 8;

  // One row of the directed table; known marks an expected value typed in by hand.
  typedef struct packed {
    logic [2:0]   mode;
    logic [W-1:0] progress;
    logic         known;
    logic [W-1:0] eased;
  } stim_row_t;

  // One expected result, with the transaction that caused it.
  typedef struct {
    logic [2:0]   mode;
    logic [W-1:0] progress;
    logic [W-1:0] eased;
  } eased_exp_t;

  localparam int DIR_ROWS = 26;
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{ecu_pkg::MODE_LINEAR,       17'd0,      1'b1, 17'd0},
    '{ecu_pkg::MODE_LINEAR,       17'd65536,  1'b1, 17'd65536},
    '{ecu_pkg::MODE_LINEAR,       17'd131071, 1'b1, 17'd65536},
    '{ecu_pkg::MODE_LINEAR_ALT,   17'd12345,  1'b1, 17'd12345},
    '{ecu_pkg::MODE_LINEAR_ALT,   17'd65537,  1'b1, 17'd65536},
    '{ecu_pkg::MODE_SINE_OUT,     17'd0,      1'b1, 17'd0},
    '{ecu_pkg::MODE_SINE_OUT,     17'd65536,  1'b0, 17'd0},
    '{ecu_pkg::MODE_SINE_OUT,     17'd256,    1'b0, 17'd0},
    '{ecu_pkg::MODE_SINE_OUT,     17'd65535,  1'b0, 17'd0},
    '{ecu_pkg::MODE_SINE_IN,      17'd0,      1'b0, 17'd0},
    '{ecu_pkg::MODE_SINE_IN,      17'd65536,  1'b1, 17'd65536},
    '{ecu_pkg::MODE_SINE_IN,      17'd100000, 1'b1, 17'd65536},
    '{ecu_pkg::MODE_SINE_INOUT,   17'd32768,  1'b1, 17'd32768},
    '{ecu_pkg::MODE_SINE_INOUT,   17'd32767,  1'b0, 17'd0},
    '{ecu_pkg::MODE_SINE_INOUT,   17'd0,      1'b0, 17'd0},
    '{ecu_pkg::MODE_SINE_INOUT,   17'd131071, 1'b0, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_OUT,   17'd0,      1'b1, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_OUT,   17'd65536,  1'b1, 17'd65536},
    '{ecu_pkg::MODE_BOUNCE_OUT,   17'd23831,  1'b0, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_OUT,   17'd23832,  1'b0, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_OUT,   17'd47663,  1'b0, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_OUT,   17'd59579,  1'b0, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_IN,    17'd0,      1'b1, 17'd0},
    '{ecu_pkg::MODE_BOUNCE_IN,    17'd65536,  1'b1, 17'd65536},
    '{ecu_pkg::MODE_BOUNCE_INOUT, 17'd32768,  1'b1, 17'd32768},
    '{ecu_pkg::MODE_BOUNCE_INOUT, 17'd131071, 1'b1, 17'd65536}
  };

  // Progress values near the edges of the sine index and the bounce segments.
  localparam int N_CORNERS = 10;
  localparam int unsigned CORNERS [N_CORNERS] = '{
    0, 256, 23831, 32768, 47662, 59578, 65280, 65536, 65537, 131071
  };

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  logic [2:0]   in_mode = ecu_pkg::MODE_LINEAR;
  logic [W-1:0] in_progress = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  logic [W-1:0] out_eased;

  // Predictor state: the constant quarter-wave sine points.
  bit [63:0] sine_points [0:SINE_PTS];

  eased_exp_t pending_eased [$];
  bit         quiet = 1'b0;
  int         fail_count = 0;
  int         checked_count = 0;
  int         sent_count = 0;
  int         above_one_count = 0;
  int         idle_cycles = 0;
  int         stall_left = 0;
  int         mode_seen [8];

  easing_curve_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_progress (in_progress),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_eased   (out_eased)
  );

  always #4 clk = ~clk;

  // Sine of an angle in Q30 radians by a truncated Taylor series.
  function automatic bit [63:0] series_sine(input bit [63:0] ang);
    bit [63:0] sq;
    bit [63:0] term;
    bit [63:0] k;
    longint    acc;
    sq   = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    k    = 1;
    while (k < 16 && term != 0) begin
      term = ((term * sq) >> 30) / ((2 * k) * (2 * k + 1));
      if (k[0]) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
      k = k + 1;
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > (longint'(1) << 30)) begin
      acc = longint'(1) << 30;
    end
    return 64'(acc);
  endfunction

  function automatic void fill_sine_points();
    bit [63:0] v;
    for (int i = 0; i <= SINE_PTS; i++) begin
      v = (series_sine((64'(i) * QUARTER_TURN_Q30) / SINE_PTS) + (64'd1 << 13)) >> 14;
      sine_points[i] = (v > UNIT) ? UNIT : v;
    end
  endfunction

  // Quarter-wave sine of a in 0..UNIT with linear interpolation between points.
  function automatic bit [63:0] sine_lookup(input bit [63:0] a);
    bit [63:0] pos;
    bit [63:0] idx;
    bit [63:0] frac;
    bit [63:0] lo;
    bit [63:0] hi;
    if (a >= UNIT) begin
      return sine_points[SINE_PTS];
    end
    pos  = a * SINE_PTS;
    idx  = pos >> 16;
    frac = pos & (UNIT - 1);
    if (idx >= SINE_PTS) begin
      return sine_points[SINE_PTS];
    end
    lo = sine_points[idx];
    hi = sine_points[idx + 1];
    if (hi < lo) begin
      hi = lo;
    end
    return lo + (((hi - lo) * frac + HALF_UNIT) >> 16);
  endfunction

  // Out-bounce: four quadratic segments, exact rational rounded half up.
  function automatic bit [63:0] bounce_core(input bit [63:0] x);
    bit [63:0] c;
    bit [63:0] k;
    bit [63:0] w;
    bit [63:0] r;
    if (11 * x < 4 * UNIT) begin
      c = 0;  k = 0;
    end else if (11 * x < 8 * UNIT) begin
      c = 12; k = 48;
    end else if (11 * x < 10 * UNIT) begin
      c = 18; k = 60;
    end else begin
      c = 21; k = 63;
    end
    w = 22 * x;
    w = (w >= c * UNIT) ? w - c * UNIT : c * UNIT - w;
    r = (w * w + k * UNIT * UNIT + 32 * UNIT) >> 22;
    return (r > UNIT) ? UNIT : r;
  endfunction

  function automatic logic [W-1:0] predict_eased(input logic [2:0] mode,
                                                 input logic [W-1:0] progress);
    bit [63:0] p;
    bit [63:0] r;
    p = 64'(progress);
    if (p > UNIT) begin
      p = UNIT;
    end
    case (mode)
      ecu_pkg::MODE_SINE_IN: begin
        r = UNIT - sine_lookup(UNIT - p);
      end
      ecu_pkg::MODE_SINE_OUT: begin
        r = sine_lookup(p);
      end
      ecu_pkg::MODE_SINE_INOUT: begin
        if (p < HALF_UNIT) r = (UNIT - sine_lookup(UNIT - 2 * p) + 1) >> 1;
        else r = (UNIT + sine_lookup(2 * p - UNIT) + 1) >> 1;
      end
      ecu_pkg::MODE_BOUNCE_IN: begin
        r = UNIT - bounce_core(UNIT - p);
      end
      ecu_pkg::MODE_BOUNCE_OUT: begin
        r = bounce_core(p);
      end
      ecu_pkg::MODE_BOUNCE_INOUT: begin
        if (p < HALF_UNIT) r = (UNIT - bounce_core(UNIT - 2 * p) + 1) >> 1;
        else r = (UNIT + bounce_core(2 * p - UNIT) + 1) >> 1;
      end
      default: begin
        r = p;
      end
    endcase
    if (r > UNIT) begin
      r = UNIT;
    end
    return r[W-1:0];
  endfunction

  // Length of an idle stretch: mostly short, a few long.
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [W-1:0] pick_progress();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 65) return W'($urandom_range(0, 65536));
    if (r < 80) begin
      v = int'(CORNERS[$urandom_range(0, N_CORNERS - 1)]) + $urandom_range(0, 4) - 2;
      if (v < 0) v = 0;
      if (v > 131071) v = 131071;
      return W'(v);
    end
    if (r < 90) return W'($urandom_range(65537, 131071));
    return W'($urandom_range(0, 131071));
  endfunction

  // Offer one transaction after an optional gap and hold it until it is taken.
  task automatic send_item(input logic [2:0] mode, input logic [W-1:0] progress,
                           input logic known, input logic [W-1:0] eased);
    int         gap;
    eased_exp_t e;
    gap = (!quiet && $urandom_range(0, 99) < 35) ? pick_idle_len() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_progress <= progress;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e.mode     = mode;
    e.progress = progress;
    e.eased    = known ? eased : predict_eased(mode, progress);
    pending_eased.push_back(e);
    sent_count++;
    mode_seen[mode]++;
    if (progress > W'(UNIT)) above_one_count++;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_eased.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stall stretches, none while a quiet stretch runs.
  always @(negedge clk) begin
    if (!rst_n || quiet) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall  <= 1'b1;
      stall_left = pick_idle_len() - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk) begin
    eased_exp_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_eased.size() == 0) begin
        $error("result with no transaction waiting: eased %0d", out_eased);
        fail_count++;
      end else begin
        e = pending_eased.pop_front();
        checked_count++;
        if (out_eased !== e.eased) begin
          $error("eased mismatch: expected %0d, actual %0d (mode %0d, progress %0d)",
                 e.eased, out_eased, e.mode, e.progress);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("[easing_curve_unit] ERROR");
      $finish;
    end
  end

  initial begin
    fill_sine_points();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed table: extremes, every curve code, saturation and segment edges.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(DIRECTED[i].mode, DIRECTED[i].progress, DIRECTED[i].known,
                DIRECTED[i].eased);
    end
    wait_for_results();

    // Random part, with quiet stretches and one full drain halfway.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      quiet = ((i % 400) >= 340);
      if (i == RANDOM_ITEMS / 2) begin
        wait_for_results();
      end
      send_item(3'($urandom_range(0, 7)), pick_progress(), 1'b0, '0);
    end
    quiet = 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_eased.size() != 0) begin
      $error("%0d expected results never arrived", pending_eased.size());
      fail_count++;
    end
    $display("Sent %0d transactions (%0d with progress above one), checked %0d results.",
             sent_count, above_one_count, checked_count);
    $display("Per curve code 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
             mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3],
             mode_seen[4], mode_seen[5], mode_seen[6], mode_seen[7]);
    if (fail_count == 0) begin
      $display("[easing_curve_unit] OK");
    end else begin
      $display("[easing_curve_unit] ERROR");
    end
    $finish;
  end

endmodule
